@@ hdl/i2d_pkg.sv @@
// Package for the int64 to double converter: types and constants.
package i2d_pkg;
    localparam int unsigned ExpTop   = 1086;
    localparam int unsigned FracBits = 52;
    localparam int unsigned DropBits = 11;

    typedef enum logic
    {
        CMD_UNSIGNED = 1'b0,
        CMD_SIGNED   = 1'b1
    } cmd_t;

    // Stage 1 to 2: magnitude and sign
    typedef struct packed
    {
        logic        neg;
        logic [63:0] mag;
    } mag_stage_t;

    // Stage 3 to 4: normalized magnitude
    typedef struct packed
    {
        logic        neg;
        logic        zero;
        logic [5:0]  lz;
        logic [63:0] norm;
    } norm_stage_t;
endpackage

@@ hdl/i2d_normalize.sv @@
// Leading-zero count and normalizing shift, two register stages.
module i2d_normalize
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  i2d_pkg::mag_stage_t       in_data,
    output logic                      out_valid,
    output i2d_pkg::norm_stage_t      out_data
);
    import i2d_pkg::*;

    logic        cnt_valid_reg;
    logic        cnt_neg_reg;
    logic        cnt_zero_reg;
    logic [5:0]  cnt_lz_reg;
    logic [63:0] cnt_mag_reg;
    logic [5:0]  lz_next;
    logic        valid_reg;
    norm_stage_t data_reg;

    // Priority search for the leading one
    always_comb
    begin
        lz_next = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (in_data.mag[i])
            begin
                lz_next = 6'(63 - i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (advance)
        begin
            cnt_valid_reg <= in_valid;
            valid_reg     <= cnt_valid_reg;
        end
    end

    // Payload: count stage, then shift stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cnt_neg_reg    <= in_data.neg;
            cnt_zero_reg   <= (in_data.mag == '0);
            cnt_lz_reg     <= lz_next;
            cnt_mag_reg    <= in_data.mag;
            data_reg.neg   <= cnt_neg_reg;
            data_reg.zero  <= cnt_zero_reg;
            data_reg.lz    <= cnt_lz_reg;
            data_reg.norm  <= cnt_mag_reg << cnt_lz_reg;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

@@ hdl/int64_to_double_converter_core.sv @@
// Top level of the int64 to double converter pipeline.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, command,     | into block
//          | value                            |
//  out     | out_valid, out_stall,            | out of block
//          | double_bits                      |
//
// One item per cycle while not stalled; four register stages: magnitude,
// leading-zero count, normalizing shift, rounding.
// Reset clears only the stage valid bits.
// The pipeline advances whenever the output register is empty or taken;
// in_stall follows out_stall only when the pipeline is full at the output.
module int64_to_double_converter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] double_bits
);
    import i2d_pkg::*;

    logic        advance;
    logic        mag_valid_reg;
    mag_stage_t  mag_reg;
    mag_stage_t  mag_next;
    logic        nrm_valid;
    norm_stage_t nrm;
    logic        out_valid_reg;
    logic [63:0] out_reg;
    logic [63:0] res_next;
    logic [63:0] base;
    logic        rnd;
    logic        sticky;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // Stage 1: sign and magnitude
    always_comb
    begin
        mag_next.neg = (cmd_t'(command) == CMD_SIGNED) && value[63];
        mag_next.mag = mag_next.neg ? (64'd0 - value) : value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mag_valid_reg <= in_valid;
            out_valid_reg <= nrm_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg <= mag_next;
            out_reg <= res_next;
        end
    end

    i2d_normalize u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (mag_valid_reg),
        .in_data   (mag_reg),
        .out_valid (nrm_valid),
        .out_data  (nrm)
    );

    // Stage 4: pack, round to nearest even, set sign
    always_comb
    begin
        base   = {1'b0, 11'(ExpTop - 32'(nrm.lz)), nrm.norm[62:DropBits]};
        rnd    = nrm.norm[DropBits-1];
        sticky = |nrm.norm[DropBits-2:0];
        res_next = base + {63'd0, rnd && (sticky || base[0])};
        if (nrm.zero)
        begin
            res_next = '0;
        end
        else if (nrm.neg)
        begin
            res_next[63] = 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign double_bits = out_reg;

`ifndef SYNTH
    // A held result must not change while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(double_bits))
        else $error("result changed under stall");
    // Stall at input only when the output is blocked
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("spurious input stall");
    // Zero input gives +0 at the output in a free-flowing pipe
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && value == 64'd0 ##1 !in_stall ##1 !in_stall
        ##1 !in_stall |=> double_bits == 64'd0)
        else $error("zero did not convert to +0");
`endif
endmodule

@@ bench/int64_to_double_converter_core_test.sv @@
// Testbench for the int64 to double converter: random and corner conversions checked per item.
module int64_to_double_converter_core_test;
    import i2d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct
    {
        cmd_t        cmd;
        logic [63:0] bits;
    } conv_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = 1'b0;
    logic [63:0] value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] double_bits;

    conv_item_t  pending_items[$];
    logic [63:0] expected_doubles[$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          hold_sender = 1'b0;
    bit          calm_phase = 1'b0;

    int64_to_double_converter_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .double_bits(double_bits)
    );

    always #5 clk = ~clk;

    // Round-to-nearest-even conversion of one integer to binary64
    function automatic logic [63:0] int_to_double(cmd_t cmd, logic [63:0] bits);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] norm;
        logic [63:0] res;
        int          lz;
        neg = (cmd == CMD_SIGNED) && bits[63];
        mag = neg ? (64'd0 - bits) : bits;
        if (mag == 64'd0)
            return 64'd0;
        lz = 0;
        while (!mag[63 - lz])
            lz++;
        norm = mag << lz;
        res = {1'b0, 11'(1086 - lz), norm[62:11]};
        if (norm[10] && ((norm[9:0] != 10'd0) || res[0]))
            res = res + 64'd1;
        res[63] = neg;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_item(cmd_t cmd, logic [63:0] bits);
        conv_item_t it;
        it.cmd = cmd;
        it.bits = bits;
        pending_items.push_back(it);
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        conv_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_doubles.push_back(int_to_double(cmd_t'(command), value));
            if (pending_items.size() > 0 && !hold_sender
                && (calm_phase || $urandom_range(99) >= 12))
            begin
                it = pending_items.pop_front();
                in_valid <= 1'b1;
                command <= it.cmd;
                value <= it.bits;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_doubles.size() == 0)
                begin
                    $display("%0t: unexpected item, actual %h", $time, double_bits);
                    error_count++;
                end
                else
                begin
                    want = expected_doubles.pop_front();
                    if (want !== double_bits)
                    begin
                        $display("%0t: double_bits expected %h actual %h",
                                 $time, want, double_bits);
                        error_count++;
                    end
                end
            end
            out_stall <= !calm_phase && ($urandom_range(99) < 12);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (quiet_cycles > 2000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int k;
        int sh;
        logic [63:0] v;
        // Corners: zero, extremes, most negative, exactness edge, ties and carry
        add_item(CMD_UNSIGNED, 64'd0);
        add_item(CMD_SIGNED, 64'd0);
        add_item(CMD_UNSIGNED, '1);
        add_item(CMD_SIGNED, '1);
        add_item(CMD_SIGNED, 64'h8000_0000_0000_0000);
        add_item(CMD_UNSIGNED, 64'h8000_0000_0000_0000);
        add_item(CMD_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
        add_item(CMD_UNSIGNED, 64'd1);
        add_item(CMD_SIGNED, 64'd1);
        add_item(CMD_UNSIGNED, 64'h001F_FFFF_FFFF_FFFF);
        add_item(CMD_UNSIGNED, 64'h0020_0000_0000_0001);
        add_item(CMD_UNSIGNED, 64'h0020_0000_0000_0003);
        add_item(CMD_UNSIGNED, 64'h0040_0000_0000_0002);
        add_item(CMD_UNSIGNED, 64'h0040_0000_0000_0006);
        add_item(CMD_UNSIGNED, 64'h0040_0000_0000_0003);
        add_item(CMD_UNSIGNED, 64'h003F_FFFF_FFFF_FFFF);
        add_item(CMD_SIGNED, 64'hFFC0_0000_0000_0001);
        add_item(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FC00);
        add_item(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_F800);
        add_item(CMD_SIGNED, 64'hAAAA_AAAA_AAAA_AAAA);
        add_item(CMD_UNSIGNED, 64'h5555_5555_5555_5555);

        // Random: varied magnitudes, with values near rounding ties
        for (k = 0; k < 1650; k++)
        begin
            v = rand64();
            sh = $urandom_range(63);
            case ($urandom_range(3))
                0: v = v >> sh;
                1: v = {v[63:11], 1'b1, 10'd0} >> sh;
                2: v = ~(v >> sh);
                default: ;
            endcase
            add_item(cmd_t'($urandom_range(1)), v);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Pause sender until drained, then a stretch with no idling
        wait (pending_items.size() < 1200);
        @(posedge clk);
        hold_sender <= 1'b1;
        wait (!in_valid && expected_doubles.size() == 0);
        @(posedge clk);
        hold_sender <= 1'b0;
        calm_phase <= 1'b1;
        wait (pending_items.size() < 800);
        @(posedge clk);
        calm_phase <= 1'b0;

        wait (pending_items.size() == 0 && !in_valid && expected_doubles.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_doubles.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/i2d_pkg.sv
hdl/i2d_normalize.sv
hdl/int64_to_double_converter_core.sv
bench/int64_to_double_converter_core_test.sv
